FILE: hdl/top_k_sorted_insert_table_top_assert.svh
// assertion macros for the top-k sorted insertion table
// used by top_k_sorted_insert_table_top, expects clk and rst_n in scope
`ifndef TOP_K_SORTED_INSERT_TABLE_TOP_ASSERT_SVH
`define TOP_K_SORTED_INSERT_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define TKS_ASSERT_NOW(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("top_k_sorted_insert_table_top: check failed");

// next-cycle implication
`define TKS_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("top_k_sorted_insert_table_top: check failed");

`endif

FILE: hdl/tks_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and name helper for the top-k sorted insertion table
// no dependencies
package tks_pkg;

    localparam int ENTRIES    = 10;
    localparam int NAME_CHARS = 8;

    localparam logic [3:0] NO_RANK = 4'hF;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } tks_cmd_t;

    typedef struct packed {
        logic clear;
        logic take_prev;
        logic load_new;
    } tks_ctrl_t;

    // keep bytes from the top down up to the first zero, at most NAME_CHARS
    function automatic logic [63:0] tks_cut_name(input logic [63:0] raw);
        logic [63:0] kept;
        logic        live;
        kept = '0;
        live = 1'b1;
        for (int n = 0; n < 8; n++)
        begin
            if (n < NAME_CHARS && live && raw[(56 - 8 * n) +: 8] != 8'h00)
            begin
                kept[(56 - 8 * n) +: 8] = raw[(56 - 8 * n) +: 8];
            end
            else
            begin
                live = 1'b0;
            end
        end
        return kept;
    endfunction

    localparam logic [63:0] TKS_DASH_NAME = tks_cut_name(64'h2D2D2D2D2D2D2D2D);

endpackage

FILE: hdl/top_k_sorted_insert_table_top.sv
`timescale 1ns / 1ps
// top level of the top-k sorted insertion table: cell chain and result register
// depends on tks_pkg, tks_cell and top_k_sorted_insert_table_top_assert.svh
//
// usage
//   commands arrive on the s_ channel, one beat per command, cmd in s_tuser
//   every command gives exactly one result beat on the m_ channel
//   insert: each cell compares the offered score with its own in parallel,
//   the first beaten cell takes the new entry and every lower cell takes its
//   upper neighbour's entry in the same cycle, the last entry drops out
//   read: returns the entry at read_index, zero beyond the table
//   clear: every cell returns to score zero and a dashed name, all together
//   the result beat is registered and appears in the cycle after the command beat
//   throughput is one command per cycle while no result is held back by m_tready
//   a result register parts the two sides: s_tready is low only while a
//   result waits and m_tready is low, so a stalled receiver holds the table
//   reset empties the result register and loads every cell with its default
//   contents at once
`include "top_k_sorted_insert_table_top_assert.svh"

module top_k_sorted_insert_table_top
    import tks_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // new_score[15:0], name_text[79:16], read_index[83:80], zero
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // placed_rank[3:0], qualified[4], entry_score[20:5],
                                   // entry_name[84:21], zero
);

    logic               s_fire;
    tks_cmd_t           cmd;
    logic signed [15:0] new_score;
    logic        [63:0] name_text;
    logic        [3:0]  read_index;
    logic        [63:0] cut_name;

    logic signed [15:0] cell_score [ENTRIES];
    logic        [63:0] cell_name  [ENTRIES];
    logic [ENTRIES-1:0] beats;
    tks_ctrl_t          cell_ctrl  [ENTRIES];

    logic               m_valid_reg;
    logic               m_valid_next;
    logic        [3:0]  rank_reg;
    logic        [3:0]  rank_next;
    logic               qual_reg;
    logic               qual_next;
    logic signed [15:0] escore_reg;
    logic signed [15:0] escore_next;
    logic        [63:0] ename_reg;
    logic        [63:0] ename_next;

    logic signed [15:0] rd_score;
    logic        [63:0] rd_name;
    logic        [3:0]  first_rank;

    assign s_tready   = !m_valid_reg || m_tready;
    assign s_fire     = s_tvalid && s_tready;
    assign cmd        = tks_cmd_t'(s_tuser);
    assign new_score  = s_tdata[15:0];
    assign name_text  = s_tdata[79:16];
    assign read_index = s_tdata[83:80];
    assign cut_name   = tks_cut_name(name_text);

    genvar k;
    generate
        for (k = 0; k < ENTRIES; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                always_comb
                begin
                    cell_ctrl[k].clear     = s_fire && cmd == CMD_CLEAR;
                    cell_ctrl[k].take_prev = 1'b0;
                    cell_ctrl[k].load_new  = s_fire && cmd == CMD_INSERT && beats[k];
                end

                tks_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (cell_ctrl[k]),
                    .new_score  (new_score),
                    .new_name   (cut_name),
                    .prev_score (new_score),
                    .prev_name  (cut_name),
                    .score      (cell_score[k]),
                    .name       (cell_name[k]),
                    .beats      (beats[k])
                );
            end
            else
            begin : g_body
                always_comb
                begin
                    cell_ctrl[k].clear     = s_fire && cmd == CMD_CLEAR;
                    cell_ctrl[k].take_prev = s_fire && cmd == CMD_INSERT && beats[k-1];
                    cell_ctrl[k].load_new  = s_fire && cmd == CMD_INSERT && beats[k];
                end

                tks_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (cell_ctrl[k]),
                    .new_score  (new_score),
                    .new_name   (cut_name),
                    .prev_score (cell_score[k-1]),
                    .prev_name  (cell_name[k-1]),
                    .score      (cell_score[k]),
                    .name       (cell_name[k]),
                    .beats      (beats[k])
                );
            end
        end
    endgenerate

    // first beaten cell, table order keeps beats monotonic
    always_comb
    begin
        first_rank = NO_RANK;
        for (int j = ENTRIES - 1; j >= 0; j--)
        begin
            if (beats[j])
            begin
                first_rank = 4'(j);
            end
        end
    end

    // read select
    always_comb
    begin
        rd_score = '0;
        rd_name  = '0;
        for (int j = 0; j < ENTRIES; j++)
        begin
            if (32'(read_index) == j)
            begin
                rd_score = cell_score[j];
                rd_name  = cell_name[j];
            end
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        rank_next    = rank_reg;
        qual_next    = qual_reg;
        escore_next  = escore_reg;
        ename_next   = ename_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (s_fire)
        begin
            m_valid_next = 1'b1;
            rank_next    = '0;
            qual_next    = 1'b0;
            escore_next  = '0;
            ename_next   = '0;
            unique case (cmd)
                CMD_INSERT:
                begin
                    rank_next = first_rank;
                    qual_next = |beats;
                end
                CMD_READ:
                begin
                    escore_next = rd_score;
                    ename_next  = rd_name;
                end
                default:
                begin
                    rank_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg   <= rank_next;
        qual_reg   <= qual_next;
        escore_reg <= escore_next;
        ename_reg  <= ename_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, ename_reg, escore_reg, qual_reg, rank_reg};

    // table stays in descending order
    generate
        for (k = 0; k < ENTRIES - 1; k++)
        begin : g_order_chk
            `TKS_ASSERT_NOW(a_descending, 1'b1, cell_score[k] >= cell_score[k+1])
        end
    endgenerate

    `TKS_ASSERT_NOW(a_qual_rank, m_valid_reg && qual_reg, 32'(rank_reg) < ENTRIES)
    `TKS_ASSERT_NEXT(a_clear_head, s_fire && cmd == CMD_CLEAR, cell_score[0] == 16'sd0 && cell_name[0] == TKS_DASH_NAME)
    `TKS_ASSERT_NEXT(a_miss_keeps, s_fire && cmd == CMD_INSERT && beats == '0, $stable(cell_score[ENTRIES-1]))

endmodule

FILE: hdl/tks_cell.sv
`timescale 1ns / 1ps
// one table slot: holds a score and name, compares the offered score
// depends on tks_pkg
module tks_cell
    import tks_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  tks_ctrl_t          ctrl,
    input  logic signed [15:0] new_score,
    input  logic        [63:0] new_name,
    input  logic signed [15:0] prev_score,
    input  logic        [63:0] prev_name,
    output logic signed [15:0] score,
    output logic        [63:0] name,
    output logic               beats
);

    logic signed [15:0] score_reg;
    logic signed [15:0] score_next;
    logic        [63:0] name_reg;
    logic        [63:0] name_next;

    always_comb
    begin
        score_next = score_reg;
        name_next  = name_reg;
        if (ctrl.clear)
        begin
            score_next = '0;
            name_next  = TKS_DASH_NAME;
        end
        else if (ctrl.take_prev)
        begin
            score_next = prev_score;
            name_next  = prev_name;
        end
        else if (ctrl.load_new)
        begin
            score_next = new_score;
            name_next  = new_name;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg <= '0;
            name_reg  <= TKS_DASH_NAME;
        end
        else
        begin
            score_reg <= score_next;
            name_reg  <= name_next;
        end
    end

    assign score = score_reg;
    assign name  = name_reg;
    assign beats = new_score > score_reg;

endmodule
